// ----- rtl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types and constants shared by the binary max-heap queue modules.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;

    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] popped_value;
        logic signed [KEY_W-1:0] top_value;
        logic [COUNT_W-1:0]      count;
        logic [STAT_W-1:0]       status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_CHECK,
        S_UP_CMP,
        S_POP_RD_LAST,
        S_POP_LOAD_LAST,
        S_DN_CHECK,
        S_DN_RD_RIGHT,
        S_DN_CMP,
        S_FINISH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic push_start;
        logic pop_start;
        logic reject_full;
        logic reject_empty;
        logic up_place;
        logic rd_parent;
        logic up_cmp;
        logic rd_last;
        logic load_last;
        logic dn_place;
        logic rd_left;
        logic rd_right;
        logic dn_cmp;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_pop;
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic up_gt;
        logic has_left;
        logic dn_move;
        logic out_stall;
    } dp_status_t;

endpackage

// ----- rtl/bmhq_ram.sv -----
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bmhq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for push (sift-up) and pop (sift-down) of the heap queue.
// ----------------------------------------------------------------------------
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!sts.op_pop) begin
                    state_next = sts.full ? S_FINISH : S_UP_CHECK;
                end else if (sts.empty || sts.last_one) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_POP_RD_LAST;
                end
            end
            S_UP_CHECK:      state_next = sts.pos_zero ? S_FINISH : S_UP_CMP;
            S_UP_CMP:        state_next = sts.up_gt ? S_UP_CHECK : S_FINISH;
            S_POP_RD_LAST:   state_next = S_POP_LOAD_LAST;
            S_POP_LOAD_LAST: state_next = S_DN_CHECK;
            S_DN_CHECK:      state_next = sts.has_left ? S_DN_RD_RIGHT : S_FINISH;
            S_DN_RD_RIGHT:   state_next = S_DN_CMP;
            S_DN_CMP:        state_next = sts.dn_move ? S_DN_CHECK : S_FINISH;
            S_FINISH: begin
                if (!sts.out_stall) begin
                    state_next = S_IDLE;
                end
            end
            default:         state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_DISPATCH: begin
                if (!sts.op_pop) begin
                    cmd.reject_full = sts.full;
                    cmd.push_start  = !sts.full;
                end else begin
                    cmd.reject_empty = sts.empty;
                    cmd.pop_start    = !sts.empty;
                end
            end
            S_UP_CHECK: begin
                cmd.up_place  = sts.pos_zero;
                cmd.rd_parent = !sts.pos_zero;
            end
            S_UP_CMP:        cmd.up_cmp    = 1'b1;
            S_POP_RD_LAST:   cmd.rd_last   = 1'b1;
            S_POP_LOAD_LAST: cmd.load_last = 1'b1;
            S_DN_CHECK: begin
                cmd.dn_place = !sts.has_left;
                cmd.rd_left  = sts.has_left;
            end
            S_DN_RD_RIGHT:   cmd.rd_right  = 1'b1;
            S_DN_CMP:        cmd.dn_cmp    = 1'b1;
            S_FINISH:        cmd.finish    = !sts.out_stall;
            default:         cmd           = '0;
        endcase
    end

endmodule

// ----- rtl/bmhq_dpath.sv -----
// ----------------------------------------------------------------------------
// bmhq_dpath
// Heap store, moving key, position and count registers, and result register.
// ----------------------------------------------------------------------------
module bmhq_dpath
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    output dp_status_t sts,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    logic                    op_reg;
    logic signed [KEY_W-1:0] in_val_reg;
    logic signed [KEY_W-1:0] cur_reg;
    logic signed [KEY_W-1:0] left_val_reg;
    logic signed [KEY_W-1:0] popped_reg;
    logic signed [KEY_W-1:0] root_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [AW-1:0]           pos_reg;
    logic [CW-1:0]           count_reg;
    out_item_t               out_reg;
    logic                    m_valid_reg;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic [KEY_W-1:0]        wdata;
    logic [AW-1:0]           raddr;
    logic [KEY_W-1:0]        rdata;
    logic signed [KEY_W-1:0] rkey;

    logic [AW-1:0]           parent;
    logic [IW-1:0]           left_ext;
    logic [IW-1:0]           right_ext;
    logic [IW-1:0]           cnt_ext;
    logic                    has_left;
    logic                    has_right;
    logic                    up_gt;
    logic                    take_left;
    logic                    take_right;
    logic signed [KEY_W-1:0] best_val;

    bmhq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rkey      = $signed(rdata);
    assign parent    = AW'((pos_reg - AW'(1)) >> 1);
    assign left_ext  = IW'({pos_reg, 1'b1});
    assign right_ext = left_ext + IW'(1);
    assign cnt_ext   = IW'(count_reg);
    assign has_left  = left_ext < cnt_ext;
    assign has_right = right_ext < cnt_ext;
    assign up_gt     = cur_reg > rkey;

    // larger child wins only when strictly greater than the moving key
    assign take_left  = left_val_reg > cur_reg;
    assign best_val   = take_left ? left_val_reg : cur_reg;
    assign take_right = has_right && (rkey > best_val);

    always_comb begin
        raddr = '0;
        if (cmd.rd_parent) begin
            raddr = parent;
        end else if (cmd.rd_last) begin
            raddr = count_reg[AW-1:0];
        end else if (cmd.rd_left) begin
            raddr = left_ext[AW-1:0];
        end else if (cmd.rd_right) begin
            raddr = right_ext[AW-1:0];
        end
    end

    always_comb begin
        we    = cmd.up_place || cmd.dn_place || cmd.up_cmp || cmd.dn_cmp;
        waddr = pos_reg;
        wdata = cur_reg;
        if (cmd.up_cmp && up_gt) begin
            wdata = rdata;
        end else if (cmd.dn_cmp && take_right) begin
            wdata = rdata;
        end else if (cmd.dn_cmp && take_left) begin
            wdata = left_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_item.operation;
            in_val_reg <= s_item.value;
            popped_reg <= '0;
            status_reg <= ST_OK;
        end
        if (cmd.reject_full) begin
            status_reg <= ST_FULL;
        end
        if (cmd.reject_empty) begin
            status_reg <= ST_EMPTY;
        end
        if (cmd.push_start) begin
            cur_reg <= in_val_reg;
            pos_reg <= count_reg[AW-1:0];
        end
        if (cmd.pop_start) begin
            popped_reg <= root_reg;
            pos_reg    <= '0;
        end
        if (cmd.up_cmp && up_gt) begin
            pos_reg <= parent;
        end
        if (cmd.load_last) begin
            cur_reg <= rkey;
        end
        if (cmd.rd_right) begin
            left_val_reg <= rkey;
        end
        if (cmd.dn_cmp) begin
            if (take_right) begin
                pos_reg <= right_ext[AW-1:0];
            end else if (take_left) begin
                pos_reg <= left_ext[AW-1:0];
            end
        end
        // shadow copy of slot zero for the top of queue
        if (we && (waddr == '0)) begin
            root_reg <= $signed(wdata);
        end
        if (cmd.finish) begin
            out_reg.popped_value <= popped_reg;
            out_reg.top_value    <= (count_reg != '0) ? root_reg : '0;
            out_reg.count        <= COUNT_W'(count_reg);
            out_reg.status       <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.push_start) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.pop_start) begin
                count_reg <= count_reg - CW'(1);
            end
            m_valid_reg <= cmd.finish || (m_valid_reg && !m_ready);
        end
    end

    always_comb begin
        sts.op_pop    = (op_reg == OP_POP);
        sts.full      = (count_reg == CW'(CAPACITY));
        sts.empty     = (count_reg == '0);
        sts.last_one  = (count_reg == CW'(1));
        sts.pos_zero  = (pos_reg == '0);
        sts.up_gt     = up_gt;
        sts.has_left  = has_left;
        sts.dn_move   = take_left || take_right;
        sts.out_stall = m_valid_reg && !m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

// ----- rtl/binary_max_heap_queue_top.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Max-priority queue of signed 32-bit keys held as a binary heap.
// ----------------------------------------------------------------------------
// Each item is a push or a pop and returns exactly one result with the popped
// key, the current maximum, the entry count and a status code. The heap lives
// in a single RAM with one write and one registered read port, so each level
// of a sift costs a read-then-compare. A push places the new key in the last
// slot and climbs it level by level until it ends at the root or stops below
// a parent that is not smaller; a pop moves the last key to the root and sinks
// it level by level until it ends in a leaf or stops above its children.
// Rejected items and a pop of the only entry skip the sift. An item's result
// is loaded only once any previous result has been taken.
// The result sits in an output register, so work on the next item starts
// while the previous result waits to be taken.
module binary_max_heap_queue_top
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    bmhq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    bmhq_dpath #(
        .CAPACITY(CAPACITY)
    ) u_dpath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .sts    (sts),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

endmodule

// ----- tb/tb_binary_max_heap_queue_top.sv -----
// ----------------------------------------------------------------------------
// tb_binary_max_heap_queue_top
// Self-checking testbench for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
// A behavioral heap of the same capacity predicts every result when an item is
// accepted. A checker process compares each result field by field against the
// oldest prediction. Stimulus covers key extremes, ties, push to a full heap,
// pop from an empty heap, long random push/pop mixes, a long receiver hold-off
// and back-to-back streaming.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue_top;
    import bmhq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_CAP    = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // predicted heap contents and count
    logic signed [KEY_W-1:0] heap_mem [HEAP_CAP];
    int                      heap_cnt;
    out_item_t               pending_results [$];

    int mismatches;
    int quiet_cycles;
    bit no_idle;
    bit hold_req;

    binary_max_heap_queue_top #(
        .CAPACITY(HEAP_CAP)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic out_item_t heap_predict(in_item_t it);
        out_item_t               res;
        int                      pos;
        int                      lft;
        int                      rgt;
        int                      best;
        bit                      settled;
        logic signed [KEY_W-1:0] tmp;
        res = '0;
        res.status = ST_OK;
        if (it.operation == OP_PUSH) begin
            if (heap_cnt >= HEAP_CAP) begin
                res.status = ST_FULL;
            end else begin
                heap_mem[heap_cnt] = it.value;
                pos = heap_cnt;
                while (pos > 0 && heap_mem[pos] > heap_mem[(pos - 1) / 2]) begin
                    tmp = heap_mem[pos];
                    heap_mem[pos] = heap_mem[(pos - 1) / 2];
                    heap_mem[(pos - 1) / 2] = tmp;
                    pos = (pos - 1) / 2;
                end
                heap_cnt++;
            end
        end else begin
            if (heap_cnt == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.popped_value = heap_mem[0];
                heap_cnt--;
                if (heap_cnt > 0) begin
                    heap_mem[0] = heap_mem[heap_cnt];
                    pos = 0;
                    settled = 1'b0;
                    while (!settled) begin
                        lft  = 2 * pos + 1;
                        rgt  = lft + 1;
                        best = pos;
                        if (lft < heap_cnt && heap_mem[lft] > heap_mem[best]) best = lft;
                        if (rgt < heap_cnt && heap_mem[rgt] > heap_mem[best]) best = rgt;
                        if (best == pos) begin
                            settled = 1'b1;
                        end else begin
                            tmp = heap_mem[pos];
                            heap_mem[pos] = heap_mem[best];
                            heap_mem[best] = tmp;
                            pos = best;
                        end
                    end
                end
            end
        end
        res.top_value = (heap_cnt > 0) ? heap_mem[0] : '0;
        res.count     = heap_cnt[COUNT_W-1:0];
        return res;
    endfunction

    // mix of full-range keys, a narrow band for ties and the extremes
    function automatic logic signed [KEY_W-1:0] rand_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 5))
            0: k = $signed($urandom_range(0, 16)) - 8;
            1: k = 32'sh7fff_ffff;
            2: k = 32'sh8000_0000;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic offer_item(logic op, logic signed [KEY_W-1:0] key);
        in_item_t it;
        int       gap;
        it.operation = op;
        it.value     = key;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_results.push_back(heap_predict(it));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic test_directed_edges();
        offer_item(OP_POP, 32'sh0);
        offer_item(OP_POP, 32'shffff_ffff);     // value ignored on a pop
        offer_item(OP_PUSH, 32'sh7fff_ffff);
        offer_item(OP_PUSH, 32'sh8000_0000);
        offer_item(OP_PUSH, 32'sh0);
        offer_item(OP_PUSH, -32'sd1);
        offer_item(OP_PUSH, 32'sd5);
        offer_item(OP_PUSH, 32'sd5);            // equal keys
        offer_item(OP_PUSH, 32'sh7fff_ffff);
        repeat (7) offer_item(OP_POP, $urandom);
        offer_item(OP_POP, 32'sh7fff_ffff);
        offer_item(OP_PUSH, 32'sh8000_0000);
        offer_item(OP_POP, 32'sh0);
    endtask

    task automatic test_fill_and_drain();
        while (heap_cnt < HEAP_CAP) offer_item(OP_PUSH, rand_key());
        offer_item(OP_PUSH, 32'sh7fff_ffff);    // rejected, heap full
        offer_item(OP_PUSH, $urandom);
        while (heap_cnt > 0) offer_item(OP_POP, $urandom);
        offer_item(OP_POP, $urandom);
    endtask

    task automatic test_random_mix(int n_items, int push_pct);
        repeat (n_items) begin
            if ($urandom_range(1, 100) <= push_pct) offer_item(OP_PUSH, rand_key());
            else offer_item(OP_POP, $urandom);
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random_mix(40, 75);
    endtask

    task automatic test_streaming();
        no_idle = 1'b1;
        test_random_mix(80, 55);
        no_idle = 1'b0;
    endtask

    // result acceptor with random stalls and an occasional long hold-off
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: popped %0d top %0d count %0d status %0d",
                             m_item.popped_value, m_item.top_value, m_item.count,
                             m_item.status);
            end else begin
                want = pending_results.pop_front();
                if (m_item.popped_value !== want.popped_value ||
                    m_item.top_value    !== want.top_value ||
                    m_item.count        !== want.count ||
                    m_item.status       !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected popped %0d top %0d count %0d status %0d",
                                 want.popped_value, want.top_value, want.count,
                                 want.status,
                                 ", got popped %0d top %0d count %0d status %0d",
                                 m_item.popped_value, m_item.top_value, m_item.count,
                                 m_item.status);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        heap_cnt     = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_fill_and_drain();
        test_random_mix(100, 70);
        test_backpressure();
        test_random_mix(150, 30);
        test_streaming();
        test_random_mix(150, 50);
        test_fill_and_drain();
        drain_results();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
